>>> hdl/rotation_matrix_euler_trig_core_macros.svh
// Assertion macros shared by the rotation matrix trig core.
`ifndef ROTATION_MATRIX_EULER_TRIG_CORE_MACROS_SVH
`define ROTATION_MATRIX_EULER_TRIG_CORE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define RME_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define RME_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/rme_pkg.sv
// Types, constants and helpers of the rotation matrix trig core.
package rme_pkg;

    localparam logic [14:0] ONE_Q14    = 15'd16384;
    localparam logic [28:0] ONE_SQ     = 29'd268435456;
    localparam int          NORM_STEPS = 15;
    localparam int          DIV_STEPS  = 17;
    localparam int          N_NLANES   = 5;
    localparam int          N_DLANES   = 2;

    // norm lane order
    localparam int L_YC = 0;
    localparam int L_YS = 1;
    localparam int L_RC = 2;
    localparam int L_RS = 3;
    localparam int L_SQ = 4;
    // divide lane order
    localparam int D_C = 0;
    localparam int D_S = 1;

    // pipeline stage numbers
    localparam int ST_INIT = 1;
    localparam int ST_NEND = ST_INIT + NORM_STEPS;
    localparam int ST_PREP = ST_NEND + 1;
    localparam int ST_DEND = ST_PREP + DIV_STEPS;
    localparam int ST_OUT  = ST_DEND + 1;

    typedef struct packed {
        logic signed [63:0] rem;
        logic signed [47:0] acc;
        logic        [29:0] s;
        logic        [14:0] q;
    } t_norm;

    typedef struct packed {
        logic [29:0] rem;
        logic [15:0] d;
        logic [16:0] q;
    } t_div;

    typedef struct packed {
        logic               nx_neg;
        logic               ex_neg;
        logic               cy_neg;
        logic               cz_neg;
        logic               pit90;
        logic               yaw_zero;
        logic               roll_zero;
        logic signed [15:0] cx;
        logic        [14:0] mcy;
        logic        [14:0] mcz;
        logic        [14:0] ycos;
        logic        [14:0] ysin;
        logic        [14:0] rcos;
        logic        [14:0] rsin;
        logic        [14:0] cp;
        logic               ovf_c;
        logic               ovf_s;
    } t_side;

    typedef struct packed {
        logic signed [15:0] sin_yaw;
        logic signed [15:0] pitch_sin;
        logic signed [15:0] roll_sin;
        logic signed [15:0] cos_yaw;
        logic        [14:0] pitch_cos;
        logic signed [15:0] roll_cos;
    } t_result;

    function automatic logic signed [15:0] f_clamp(input logic signed [15:0] x);
        logic signed [15:0] r;
        r = x;
        if (x > $signed({1'b0, ONE_Q14})) r = $signed({1'b0, ONE_Q14});
        if (x < -$signed({1'b0, ONE_Q14})) r = -$signed({1'b0, ONE_Q14});
        return r;
    endfunction

    function automatic logic [14:0] f_mag(input logic signed [15:0] x);
        logic signed [15:0] a;
        a = (x < 0) ? -x : x;
        return a[14:0];
    endfunction

    function automatic logic [14:0] f_sat_one(input logic [14:0] q);
        return (q > ONE_Q14) ? ONE_Q14 : q;
    endfunction

    function automatic logic signed [15:0] f_apply(input logic neg, input logic [14:0] m);
        logic signed [15:0] v;
        v = $signed({1'b0, m});
        return neg ? -v : v;
    endfunction

    // remainder starts at A - s, accumulator at (2q-1)s with q = 0
    function automatic t_norm f_norm_init(input logic [58:0] a, input logic [29:0] s);
        t_norm r;
        r.rem = $signed({5'b0, a}) - $signed({34'b0, s});
        r.acc = -$signed({18'b0, s});
        r.s   = s;
        r.q   = '0;
        return r;
    endfunction

endpackage

>>> hdl/rme_norm_cell.sv
// One bit of the scaled square root search: keeps (2q-1)^2 * s <= A.
module rme_norm_cell (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [3:0]    i_pos,
    input  rme_pkg::t_norm i_d,
    output rme_pkg::t_norm o_d
);
    import rme_pkg::*;

    logic [5:0]         w_sh_acc;
    logic [5:0]         w_sh_s;
    logic signed [63:0] w_t;
    t_norm              n_d;

    assign w_sh_acc = {2'b0, i_pos} + 6'd2;
    assign w_sh_s   = {1'b0, i_pos, 1'b0} + 6'd2;

    always_comb begin
        // growth of k^2 * s when this bit is set
        w_t = (64'($signed(i_d.acc)) <<< w_sh_acc) + ($signed({34'b0, i_d.s}) <<< w_sh_s);
        n_d = i_d;
        if (w_t <= $signed(i_d.rem)) begin
            n_d.rem = $signed(i_d.rem) - w_t;
            n_d.q   = i_d.q | (15'd1 << i_pos);
            n_d.acc = $signed(i_d.acc) + ($signed({18'b0, i_d.s}) <<< ({2'b0, i_pos} + 6'd1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_d <= n_d;
        end
    end

endmodule

>>> hdl/rme_div_cell.sv
// One quotient bit of a restoring divide.
module rme_div_cell (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [4:0]    i_pos,
    input  rme_pkg::t_div i_d,
    output rme_pkg::t_div o_d
);
    import rme_pkg::*;

    logic [32:0] w_sub;
    t_div        n_d;

    assign w_sub = {17'b0, i_d.d} << i_pos;

    always_comb begin
        n_d = i_d;
        if ({3'b0, i_d.rem} >= w_sub) begin
            n_d.rem = i_d.rem - w_sub[29:0];
            n_d.q   = i_d.q | (17'd1 << i_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_d <= n_d;
        end
    end

endmodule

>>> hdl/rotation_matrix_euler_trig_core.sv
// Top level of the rotation matrix to Euler sine/cosine core.
//
// Slave stream: one word carries the five used matrix elements, Q2.14.
// Master stream: one word carries the six sines and cosines, Q2.14.
// Inputs are clamped to plus or minus one before use.
// The block is a fixed pipeline of 36 register stages: a word is taken
// every cycle unless the receiver stalls, and its result leaves the last
// stage on the master side. Throughput is one word per cycle unless stalled.
// The depth is set by two rows of bit cells: 15 square root cells (yaw,
// pitch and roll fallback in parallel lanes) followed by 17 divide cells
// for the roll quotients, one quotient bit per cell.
// Reset (synchronous, active low) empties the pipeline; no result is lost
// or repeated afterwards as there is no state between words.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_s_axis_tready falls until the result is taken.
`include "rotation_matrix_euler_trig_core_macros.svh"

module rotation_matrix_euler_trig_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // north_x, east_x, down_x, down_y, down_z (16 bits each)
    input  logic [79:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // roll_cos[15:0], pitch_cos[30:16], cos_yaw[46:31], roll_sin[62:47],
    // pitch_sin[78:63], sin_yaw[94:79], zero pad
    output logic [95:0] o_m_axis_tdata
);
    import rme_pkg::*;

    logic               w_en;
    logic               r_vld [0:ST_OUT];
    t_side              r_sd  [0:ST_DEND];
    t_side              n_sd0;
    t_side              n_prep;
    logic        [28:0] r_sq  [0:4];
    logic        [28:0] n_sq  [0:4];
    logic signed [15:0] w_cl  [0:4];
    logic        [14:0] w_mg  [0:4];
    t_norm              r_nl  [0:N_NLANES-1];
    t_norm              w_nc  [0:N_NLANES-1][0:NORM_STEPS];
    t_div               r_dl  [0:N_DLANES-1];
    t_div               w_dc  [0:N_DLANES-1][0:DIV_STEPS];
    t_result            r_out;
    t_result            n_out;

    logic [29:0] w_sy;
    logic [29:0] w_sr2;
    logic [28:0] w_d;
    logic [14:0] w_cp;
    logic [15:0] w_dv;
    logic [29:0] w_nc_c;
    logic [29:0] w_nc_s;
    logic        w_pole;

    assign w_en            = !r_vld[ST_OUT] || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_vld[ST_OUT];
    assign o_m_axis_tdata  = {1'b0, r_out};

    // valid row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= ST_OUT; k++) r_vld[k] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_s_axis_tvalid;
            for (int k = 1; k <= ST_OUT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // stage 0: clamp and square
    always_comb begin
        for (int i = 0; i < 5; i++) begin
            w_cl[i] = f_clamp($signed(i_s_axis_tdata[16*i +: 16]));
            w_mg[i] = f_mag(w_cl[i]);
            n_sq[i] = {14'b0, w_mg[i]} * {14'b0, w_mg[i]};
        end
        n_sd0           = '0;
        n_sd0.nx_neg    = w_cl[0] < 0;
        n_sd0.ex_neg    = w_cl[1] < 0;
        n_sd0.cy_neg    = w_cl[3] < 0;
        n_sd0.cz_neg    = w_cl[4] < 0;
        n_sd0.cx        = w_cl[2];
        n_sd0.pit90     = w_mg[2] >= ONE_Q14;
        n_sd0.yaw_zero  = (w_mg[0] == '0) && (w_mg[1] == '0);
        n_sd0.roll_zero = (w_mg[3] == '0) && (w_mg[4] == '0);
        n_sd0.mcy       = w_mg[3];
        n_sd0.mcz       = w_mg[4];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 5; i++) r_sq[i] <= n_sq[i];
        end
    end

    // stage 1: seed the lanes
    assign w_sy  = {1'b0, r_sq[0]} + {1'b0, r_sq[1]};
    assign w_sr2 = {1'b0, r_sq[3]} + {1'b0, r_sq[4]};
    assign w_d   = ONE_SQ - r_sq[2];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nl[L_YC] <= f_norm_init({r_sq[0], 30'b0}, w_sy);
            r_nl[L_YS] <= f_norm_init({r_sq[1], 30'b0}, w_sy);
            r_nl[L_RC] <= f_norm_init({r_sq[4], 30'b0}, w_sr2);
            r_nl[L_RS] <= f_norm_init({r_sq[3], 30'b0}, w_sr2);
            r_nl[L_SQ] <= f_norm_init({28'b0, w_d, 2'b0}, 30'd1);
        end
    end

    // square root cell rows
    for (genvar l = 0; l < N_NLANES; l++) begin : g_nlane
        assign w_nc[l][0] = r_nl[l];
        for (genvar j = 0; j < NORM_STEPS; j++) begin : g_cell
            rme_norm_cell u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_pos (4'(NORM_STEPS - 1 - j)),
                .i_d   (w_nc[l][j]),
                .o_d   (w_nc[l][j+1])
            );
        end
    end

    // divide set-up: round to nearest as floor((2n*16384 + cp) / (2cp))
    assign w_cp   = w_nc[L_SQ][NORM_STEPS].q;
    assign w_dv   = {w_cp, 1'b0};
    assign w_nc_c = {r_sd[ST_NEND].mcz, 15'b0} + {15'b0, w_cp};
    assign w_nc_s = {r_sd[ST_NEND].mcy, 15'b0} + {15'b0, w_cp};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl[D_C] <= '{rem: w_nc_c, d: w_dv, q: '0};
            r_dl[D_S] <= '{rem: w_nc_s, d: w_dv, q: '0};
        end
    end

    // side band word at the end of the root rows, filled in with their results
    always_comb begin
        n_prep       = r_sd[ST_NEND];
        n_prep.ycos  = w_nc[L_YC][NORM_STEPS].q;
        n_prep.ysin  = w_nc[L_YS][NORM_STEPS].q;
        n_prep.rcos  = w_nc[L_RC][NORM_STEPS].q;
        n_prep.rsin  = w_nc[L_RS][NORM_STEPS].q;
        n_prep.cp    = w_cp;
        n_prep.ovf_c = {3'b0, w_nc_c} >= {w_dv, 17'b0};
        n_prep.ovf_s = {3'b0, w_nc_s} >= {w_dv, 17'b0};
    end

    // side band row
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd[0] <= n_sd0;
            for (int k = 1; k <= ST_DEND; k++) begin
                if (k == ST_PREP) r_sd[k] <= n_prep;
                else r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // divide cell rows
    for (genvar l = 0; l < N_DLANES; l++) begin : g_dlane
        assign w_dc[l][0] = r_dl[l];
        for (genvar j = 0; j < DIV_STEPS; j++) begin : g_cell
            rme_div_cell u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_pos (5'(DIV_STEPS - 1 - j)),
                .i_d   (w_dc[l][j]),
                .o_d   (w_dc[l][j+1])
            );
        end
    end

    // final selection
    always_comb begin
        t_side       sd;
        logic [16:0] qc;
        logic [16:0] qs;
        logic [14:0] qc_mag;
        logic        s_bad;
        logic        fb;
        sd     = r_sd[ST_DEND];
        qc     = w_dc[D_C][DIV_STEPS].q;
        qs     = w_dc[D_S][DIV_STEPS].q;
        qc_mag = (sd.ovf_c || qc > {2'b0, ONE_Q14}) ? ONE_Q14 : qc[14:0];
        s_bad  = sd.ovf_s || (qs > 17'd32768) || ((qs == 17'd32768) && !sd.cy_neg);
        fb     = sd.pit90 || s_bad;

        n_out.pitch_sin = -sd.cx;
        n_out.pitch_cos = sd.pit90 ? '0 : sd.cp;
        n_out.cos_yaw   = sd.yaw_zero ? '0 : f_apply(sd.nx_neg, f_sat_one(sd.ycos));
        n_out.sin_yaw   = sd.yaw_zero ? '0 : f_apply(sd.ex_neg, f_sat_one(sd.ysin));
        if (!fb) begin
            n_out.roll_cos = f_apply(sd.cz_neg, qc_mag);
            n_out.roll_sin = sd.cy_neg ? -$signed(qs[15:0]) : $signed(qs[15:0]);
        end else if (sd.roll_zero) begin
            n_out.roll_cos = $signed({1'b0, ONE_Q14});
            n_out.roll_sin = '0;
        end else begin
            n_out.roll_cos = f_apply(sd.cz_neg, f_sat_one(sd.rcos));
            n_out.roll_sin = f_apply(sd.cy_neg, f_sat_one(sd.rsin));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign w_pole = r_vld[ST_OUT] && (f_mag(r_out.pitch_sin) == ONE_Q14);

    `RME_ASSERT_NEXT(a_word_enters, i_s_axis_tvalid && o_s_axis_tready, r_vld[0], "word lost")
    `RME_ASSERT_NOW(a_stall_holds, r_vld[ST_OUT] && !i_m_axis_tready, !o_s_axis_tready, "stall leak")
    `RME_ASSERT_NOW(a_pitch_range, r_vld[ST_OUT], r_out.pitch_cos <= ONE_Q14, "pitch above one")
    `RME_ASSERT_NOW(a_pitch_pole, w_pole, r_out.pitch_cos == '0, "pitch not zero at the pole")

endmodule

>>> dv/rotation_matrix_euler_trig_core_checker.sv
// Checker: predicts the Euler sines and cosines of each matrix word and compares results.
module rotation_matrix_euler_trig_core_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [79:0] i_s_axis_tdata,
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [95:0] i_m_axis_tdata,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE = 16384;

    logic [95:0] trig_words_due[$];
    int          fail_count = 0;

    assign o_pending    = trig_words_due.size();
    assign o_fail_count = fail_count;

    function automatic longint clamp_one(input logic [15:0] v);
        longint x;
        x = longint'($signed(v));
        if (x > ONE) x = ONE;
        if (x < -ONE) x = -ONE;
        return x;
    endfunction

    // largest q with (2q-1)^2 * s <= 4 a^2 2^28, capped at one
    function automatic longint unit_scale(input longint a, input longint s);
        longint m, q, t, k, rhs;
        m = (a < 0) ? -a : a;
        rhs = (m * m) <<< 30;
        q = 0;
        for (int b = 14; b >= 0; b--) begin
            t = q | (longint'(1) <<< b);
            k = 2 * t - 1;
            if (k * k * s <= rhs) q = t;
        end
        if (q > ONE) q = ONE;
        return (a < 0) ? -q : q;
    endfunction

    function automatic longint root_round(input longint d);
        longint q, t, k;
        q = 0;
        for (int b = 14; b >= 0; b--) begin
            t = q | (longint'(1) <<< b);
            k = 2 * t - 1;
            if (k * k <= 4 * d) q = t;
        end
        return q;
    endfunction

    function automatic longint quot_q14(input longint n, input longint d);
        longint m, q;
        m = (n < 0) ? -n : n;
        q = (2 * m * ONE + d) / (2 * d);
        return (n < 0) ? -q : q;
    endfunction

    function automatic logic [95:0] predict_trig(input logic [79:0] w);
        longint nx, ex, cx, cy, cz, cyaw, syaw, cp, croll, sroll, qc, qs, sy, sr;
        logic fb;
        logic [95:0] r;
        nx = clamp_one(w[15:0]);
        ex = clamp_one(w[31:16]);
        cx = clamp_one(w[47:32]);
        cy = clamp_one(w[63:48]);
        cz = clamp_one(w[79:64]);
        croll = ONE;
        sroll = 0;
        fb = 1'b0;
        sy = nx * nx + ex * ex;
        if (sy == 0) begin
            cyaw = 0;
            syaw = 0;
        end else begin
            cyaw = unit_scale(nx, sy);
            syaw = unit_scale(ex, sy);
        end
        if (cx >= ONE || cx <= -ONE) begin
            cp = 0;
            fb = 1'b1;
        end else begin
            cp = root_round(ONE * ONE - cx * cx);
            qc = quot_q14(cz, cp);
            if (qc > ONE) qc = ONE;
            if (qc < -ONE) qc = -ONE;
            croll = qc;
            qs = quot_q14(cy, cp);
            if (qs > 32767 || qs < -32768) fb = 1'b1;
            else sroll = qs;
        end
        if (fb) begin
            sr = cy * cy + cz * cz;
            if (sr == 0) begin
                croll = ONE;
                sroll = 0;
            end else begin
                croll = unit_scale(cz, sr);
                sroll = unit_scale(cy, sr);
            end
        end
        r = '0;
        r[15:0] = croll[15:0];
        r[30:16] = cp[14:0];
        r[46:31] = cyaw[15:0];
        r[62:47] = sroll[15:0];
        r[78:63] = 16'(-cx);
        r[94:79] = syaw[15:0];
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [15:0] e, input logic [15:0] a);
        if (e !== a) begin
            $error("%s expected %0d actual %0d", name, $signed(e), $signed(a));
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        logic [95:0] e, a;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && i_s_axis_tready)
                trig_words_due.push_back(predict_trig(i_s_axis_tdata));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                a = i_m_axis_tdata;
                if (trig_words_due.size() == 0) begin
                    $error("result word with none expected: %h", a);
                    fail_count++;
                end else begin
                    e = trig_words_due.pop_front();
                    compare_field("roll_cos", e[15:0], a[15:0]);
                    compare_field("pitch_cos", {1'b0, e[30:16]}, {1'b0, a[30:16]});
                    compare_field("cos_yaw", e[46:31], a[46:31]);
                    compare_field("roll_sin", e[62:47], a[62:47]);
                    compare_field("pitch_sin", e[78:63], a[78:63]);
                    compare_field("sin_yaw", e[94:79], a[94:79]);
                    compare_field("pad", {15'b0, e[95]}, {15'b0, a[95]});
                end
            end
        end
    end
endmodule

>>> dv/rotation_matrix_euler_trig_core_tb.sv
// Testbench top: drives matrix words, stalls the receiver and reports the verdict.
module rotation_matrix_euler_trig_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 1930;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    logic        hold_off = 1'b0;
    logic        calm = 1'b0;

    always #4 i_clk = ~i_clk;

    rotation_matrix_euler_trig_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready), .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready), .o_m_axis_tdata(m_tdata)
    );

    rotation_matrix_euler_trig_core_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .i_s_axis_tready(s_tready), .i_s_axis_tdata(s_tdata),
        .i_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready), .i_m_axis_tdata(m_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic logic [15:0] pick_elem();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 16'(16384);
        if (r == 1) return 16'(-16384);
        if (r == 2) return 16'h0000;
        if (r == 3) return 16'($urandom);
        if (r < 7) return 16'($signed($urandom_range(0, 400)) - 200);
        if (r < 10) return 16'($signed($urandom_range(16000, 16384)) * ($urandom_range(0, 1) ? 1 : -1));
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    // offer one word and hold it until taken; drop valid while idling
    task automatic send_word(input logic [79:0] w);
        while (!calm && $urandom_range(0, 99) < 11) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic send_idle();
        s_tvalid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_tready <= !hold_off && (calm || $urandom_range(0, 99) >= 11);
    end

    // long receiver hold-off so the pipeline fills and stalls the input
    initial begin
        repeat (300) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (200) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        logic [15:0] e[5];
        logic [15:0] dv[22][5];
        dv = '{
            '{16'(16384), 16'h0, 16'h0, 16'h0, 16'(16384)},
            '{16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
            '{16'(-16384), 16'(-16384), 16'(-16384), 16'(-16384), 16'(-16384)},
            '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF},
            '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000},
            '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
            '{16'h0, 16'(16384), 16'(16384), 16'h0, 16'h0},
            '{16'h0, 16'(16384), 16'(-16384), 16'(300), 16'(-400)},
            '{16'(11585), 16'(11585), 16'(11585), 16'(8192), 16'(8192)},
            '{16'h1, 16'h0, 16'(16383), 16'(16384), 16'h0},
            '{16'h0, 16'h1, 16'(-16383), 16'(-16384), 16'(16384)},
            '{16'(5), 16'(-5), 16'(16380), 16'(-16384), 16'(-16384)},
            '{16'(16384), 16'(16384), 16'(16000), 16'(16384), 16'(-16384)},
            '{16'(-1), 16'(1), 16'(1), 16'(-1), 16'(1)},
            '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555},
            '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA},
            '{16'(9459), 16'(-9459), 16'(-9459), 16'(9459), 16'(9459)},
            '{16'(-16384), 16'h0, 16'(8192), 16'(-14189), 16'(0)},
            '{16'h0, 16'(-16384), 16'(16384), 16'h0, 16'(-1)},
            '{16'(100), 16'(200), 16'(16383), 16'h1, 16'h0},
            '{16'(-7), 16'(3), 16'(-16384), 16'(5), 16'(-5)},
            '{16'(12000), 16'(-12000), 16'(15000), 16'(12000), 16'(-6000)}
        };
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dv[i]) send_word({dv[i][4], dv[i][3], dv[i][2], dv[i][1], dv[i][0]});
        for (int n = 0; n < N_RANDOM; n++) begin
            calm <= (n >= 900 && n < 1100);
            foreach (e[k]) e[k] = pick_elem();
            send_word({e[4], e[3], e[2], e[1], e[0]});
        end
        send_idle();
        calm <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
